// ===== src/mffd_pkg.sv =====
package mffd_pkg;

  localparam int unsigned FullLen = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameId  = 2'd0,
    CfgNodeId   = 2'd1,
    CfgLimit    = 2'd2,
    CfgReserved = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    KindFrame = 1'b0,
    KindTick  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [3:0]  node_id;
    logic [31:0] limit_ms;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic        is_extended;
    logic [28:0] frame_id;
    logic [3:0]  data_length;
    logic [63:0] payload;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic               went_offline;
    logic               online;
    logic [3:0]         reported_id;
    logic [3:0]         fault_code;
    logic signed [15:0] position_raw;
    logic signed [31:0] position_total;
    logic signed [11:0] speed_raw;
    logic signed [11:0] torque_val;
    logic [7:0]         driver_temp;
    logic [7:0]         rotor_temp;
  } result_t;

endpackage

// ===== src/motor_feedback_frame_decoder.sv =====
// Channel   Handshake                  Payload
// cfg       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in        in_valid_i / in_ready_o    kind_i .. now_ms_i
// out       out_valid_o / out_ready_i  accepted_o .. rotor_temp_o
//
// One beat in per cycle while the output is not stalled; an accepted input beat is held in the input register
// until the result register can take it. The decode and state update sit between the two registers.
// Reset empties both stages, clears the decoder state and returns the configuration to its defaults.
// A stalled output holds its beat; the input register takes one more beat, then in_ready_o drops.
module motor_feedback_frame_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mffd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mffd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic                          is_extended_i,
  input  logic [28:0]                   frame_id_i,
  input  logic [3:0]                    data_length_i,
  input  logic [63:0]                   payload_i,
  input  logic [31:0]                   now_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          accepted_o,
  output logic                          went_offline_o,
  output logic                          online_o,
  output logic [3:0]                    reported_id_o,
  output logic [3:0]                    fault_code_o,
  output logic signed [15:0]            position_raw_o,
  output logic signed [31:0]            position_total_o,
  output logic signed [11:0]            speed_raw_o,
  output logic signed [11:0]            torque_val_o,
  output logic [7:0]                    driver_temp_o,
  output logic [7:0]                    rotor_temp_o
);

  mffd_pkg::cfg_t    cfg;
  mffd_pkg::item_t   item_q;
  mffd_pkg::result_t res_d, res_q;
  logic              in_valid_q, out_valid_q, fire;

  assign cfg_ready_o = 1'b1;

  mffd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= '{kind: kind_i, is_extended: is_extended_i, frame_id: frame_id_i,
                  data_length: data_length_i, payload: payload_i, now_ms: now_ms_i};
    end
  end

  mffd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = res_q.accepted;
  assign went_offline_o   = res_q.went_offline;
  assign online_o         = res_q.online;
  assign reported_id_o    = res_q.reported_id;
  assign fault_code_o     = res_q.fault_code;
  assign position_raw_o   = res_q.position_raw;
  assign position_total_o = res_q.position_total;
  assign speed_raw_o      = res_q.speed_raw;
  assign torque_val_o     = res_q.torque_val;
  assign driver_temp_o    = res_q.driver_temp;
  assign rotor_temp_o     = res_q.rotor_temp;

endmodule

// ===== src/mffd_cfg.sv =====
module mffd_cfg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [mffd_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [mffd_pkg::CfgDataW-1:0]         cfg_data_i,
  output mffd_pkg::cfg_t                        cfg_o
);

  mffd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (mffd_pkg::cfg_idx_e'(cfg_index_i))
        mffd_pkg::CfgFrameId: cfg_d.frame_id = cfg_data_i[10:0];
        mffd_pkg::CfgNodeId:  cfg_d.node_id  = cfg_data_i[3:0];
        mffd_pkg::CfgLimit:   cfg_d.limit_ms = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_id <= 11'd0;
      cfg_q.node_id  <= 4'd1;
      cfg_q.limit_ms <= 32'd100;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/mffd_core.sv =====
module mffd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  mffd_pkg::item_t   item_i,
  input  mffd_pkg::cfg_t    cfg_i,
  output mffd_pkg::result_t res_o
);

  logic        online_q, online_d;
  logic [31:0] last_rx_q, last_rx_d;
  logic [15:0] last_pos_q, last_pos_d;
  logic [31:0] total_q, total_d;
  logic [7:0]  id_err_q, id_err_d;
  logic [11:0] speed_q, speed_d;
  logic [11:0] torque_q, torque_d;
  logic [15:0] temps_q, temps_d;

  logic [7:0]  b0, b4;
  logic [15:0] pos, diff;
  logic [31:0] elapsed;
  logic        match, timeout;

  always_comb begin
    b0      = item_i.payload[7:0];
    b4      = item_i.payload[39:32];
    pos     = {item_i.payload[15:8], item_i.payload[23:16]};
    diff    = pos - last_pos_q;
    elapsed = item_i.now_ms - last_rx_q;
    match   = (mffd_pkg::kind_e'(item_i.kind) == mffd_pkg::KindFrame)
            && !item_i.is_extended
            && (item_i.data_length >= 4'(mffd_pkg::FullLen))
            && (item_i.frame_id == {18'd0, cfg_i.frame_id})
            && (b0[3:0] == cfg_i.node_id);
    timeout = (mffd_pkg::kind_e'(item_i.kind) == mffd_pkg::KindTick)
            && online_q && (elapsed > cfg_i.limit_ms);

    online_d   = online_q;
    last_rx_d  = last_rx_q;
    last_pos_d = last_pos_q;
    total_d    = total_q;
    id_err_d   = id_err_q;
    speed_d    = speed_q;
    torque_d   = torque_q;
    temps_d    = temps_q;
    if (match) begin
      total_d    = online_q ? total_q + {{16{diff[15]}}, diff} : {{16{pos[15]}}, pos};
      last_pos_d = pos;
      id_err_d   = b0;
      speed_d    = {item_i.payload[31:24], b4[7:4]};
      torque_d   = {b4[3:0], item_i.payload[47:40]};
      temps_d    = item_i.payload[63:48];
      last_rx_d  = item_i.now_ms;
      online_d   = 1'b1;
    end else if (timeout) begin
      online_d   = 1'b0;
    end

    res_o.accepted       = match;
    res_o.went_offline   = timeout;
    res_o.online         = online_d;
    res_o.reported_id    = id_err_d[3:0];
    res_o.fault_code     = id_err_d[7:4];
    res_o.position_raw   = last_pos_d;
    res_o.position_total = total_d;
    res_o.speed_raw      = speed_d;
    res_o.torque_val     = torque_d;
    res_o.driver_temp    = temps_d[7:0];
    res_o.rotor_temp     = temps_d[15:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      online_q   <= 1'b0;
      last_rx_q  <= '0;
      last_pos_q <= '0;
      total_q    <= '0;
      id_err_q   <= '0;
      speed_q    <= '0;
      torque_q   <= '0;
      temps_q    <= '0;
    end else if (fire_i) begin
      online_q   <= online_d;
      last_rx_q  <= last_rx_d;
      last_pos_q <= last_pos_d;
      total_q    <= total_d;
      id_err_q   <= id_err_d;
      speed_q    <= speed_d;
      torque_q   <= torque_d;
      temps_q    <= temps_d;
    end
  end

endmodule

// ===== src/mffd_checker.sv =====
module mffd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          accepted_o,
  input logic                          went_offline_o,
  input logic                          online_o,
  input logic signed [31:0]            position_total_o
);

  a_acc_or_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(accepted_o && went_offline_o))
    else $error("accept and offline in one beat");

  a_acc_online: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepted_o) |-> online_o)
    else $error("accepted beat not online");

  a_off_offline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && went_offline_o) |-> !online_o)
    else $error("offline beat still online");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(position_total_o)))
    else $error("stalled output beat changed");

endmodule

bind motor_feedback_frame_decoder mffd_checker u_mffd_checker (.*);
